// ===== rtl/core/ppp_pkg.sv =====
// Shared widths, register codes, pixel modes and config bundle for the point projector.
// No dependencies; every other file in rtl/core imports this package.
package ppp_pkg;

   localparam int LANE_W  = 16;   // Q8.8 coordinate or Q1.14 basis lane
   localparam int DIFF_W  = 17;   // point minus origin
   localparam int PROD_W  = 33;   // one lane product
   localparam int DOT_W   = 34;   // three-term dot product, Q.22
   localparam int REG_W   = 48;   // packed three-lane register
   localparam int SIZE_W  = 15;   // focal length and viewport sizes
   localparam int NUM_W   = 50;   // signed numerator
   localparam int DEN_W   = 48;   // unsigned denominator
   localparam int PIX_W   = 10;   // output pixel fields
   localparam int ADDR_W  = 3;    // config register index

   localparam int DEPTH_LIMIT = 4194;   // 0.001 in Q.22

   localparam int SCREEN_WIDTH_DEF  = 1024;
   localparam int SCREEN_HEIGHT_DEF = 768;

   typedef enum logic [ADDR_W-1:0] {
      REG_ORIGIN      = 3'd0,
      REG_BASIS_RIGHT = 3'd1,
      REG_BASIS_UP    = 3'd2,
      REG_BASIS_BACK  = 3'd3,
      REG_FOCAL       = 3'd4,
      REG_VIEW_W      = 3'd5,
      REG_VIEW_H      = 3'd6
   } reg_idx_type;

   typedef enum logic [1:0] {
      PIX_CALC,
      PIX_ZERO,
      PIX_MAX
   } pix_mode_type;

   typedef struct packed {
      logic [REG_W-1:0]  origin;
      logic [REG_W-1:0]  right;
      logic [REG_W-1:0]  up;
      logic [REG_W-1:0]  back;
      logic [SIZE_W-1:0] focal;
      logic [SIZE_W-1:0] view_w;
      logic [SIZE_W-1:0] view_h;
   } cfg_type;

   function automatic logic signed [LANE_W-1:0] lane(input logic [REG_W-1:0] r,
                                                      input int unsigned idx);
      return r[idx*LANE_W +: LANE_W];
   endfunction

endpackage

// ===== rtl/core/ppp_xform.sv =====
// Camera transform stages: origin subtract, lane products, dot-product sums.
// Depends on ppp_pkg.
module ppp_xform (
   input  logic                                   clock,
   input  logic [2:0]                             en,
   input  ppp_pkg::cfg_type                       cfg,
   input  logic signed [ppp_pkg::LANE_W-1:0]      point_x,
   input  logic signed [ppp_pkg::LANE_W-1:0]      point_y,
   input  logic signed [ppp_pkg::LANE_W-1:0]      point_z,
   output logic signed [ppp_pkg::DOT_W-1:0]       cam_x,
   output logic signed [ppp_pkg::DOT_W-1:0]       cam_y,
   output logic signed [ppp_pkg::DOT_W-1:0]       depth
);
   import ppp_pkg::*;

   logic signed [LANE_W-1:0] pt [3];
   logic [REG_W-1:0]         basis [3];
   logic signed [DIFF_W-1:0] d_in [3];
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [DOT_W-1:0]  sum_in [3];
   logic signed [DOT_W-1:0]  cam_x_ff, cam_y_ff, depth_ff;

   assign pt[0] = point_x;
   assign pt[1] = point_y;
   assign pt[2] = point_z;
   assign basis[0] = cfg.right;
   assign basis[1] = cfg.up;
   assign basis[2] = cfg.back;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = DIFF_W'(pt[i]) - DIFF_W'(lane(cfg.origin, i));
      end
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[j][i] = PROD_W'(d_ff[i]) * PROD_W'(lane(basis[j], i));
         end
         sum_in[j] = DOT_W'(prod_ff[j][0]) + DOT_W'(prod_ff[j][1]) + DOT_W'(prod_ff[j][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d_ff <= d_in;
      end
      if (en[1]) begin
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         cam_x_ff <= sum_in[0];
         cam_y_ff <= sum_in[1];
         depth_ff <= -sum_in[2];
      end
   end

   assign cam_x = cam_x_ff;
   assign cam_y = cam_y_ff;
   assign depth = depth_ff;

endmodule

// ===== rtl/core/ppp_persp.sv =====
// Perspective setup stages: scale by focal length and viewport, form numerators,
// denominators and screen-half products, flag trivial pixels. Depends on ppp_pkg.
module ppp_persp #(
   parameter int QW     = 10,
   parameter int HALF_X = 512,
   parameter int HALF_Y = 384,
   parameter int NW     = ppp_pkg::NUM_W - 1 + QW
) (
   input  logic                                clock,
   input  logic [3:0]                          en,
   input  ppp_pkg::cfg_type                    cfg,
   input  logic signed [ppp_pkg::DOT_W-1:0]    cam_x,
   input  logic signed [ppp_pkg::DOT_W-1:0]    cam_y,
   input  logic signed [ppp_pkg::DOT_W-1:0]    depth,
   output logic [NW-1:0]                       num_x,
   output logic [NW-1:0]                       num_y,
   output logic [ppp_pkg::DEN_W-1:0]           den_x,
   output logic [ppp_pkg::DEN_W-1:0]           den_y,
   output ppp_pkg::pix_mode_type               mode_x,
   output ppp_pkg::pix_mode_type               mode_y,
   output logic                                behind
);
   import ppp_pkg::*;

   logic signed [NUM_W-1:0] fx_ff, dx_ff, fy_ff, dy_ff;
   logic                    behind4_ff, behind5_ff, behind6_ff, behind7_ff;
   logic signed [NUM_W-1:0] nx5_ff, ny5_ff;
   logic [DEN_W-1:0]        denx5_ff, deny5_ff, denx6_ff, deny6_ff, denx7_ff, deny7_ff;
   logic [NW-1:0]           nx6_ff, ny6_ff, nx7_ff, ny7_ff;
   pix_mode_type            mx6_in, my6_in, mx6_ff, my6_ff, mx7_in, my7_in, mx7_ff, my7_ff;
   logic signed [SIZE_W:0]  fl_s, vw_s, vh_s;

   assign fl_s = $signed({1'b0, cfg.focal});
   assign vw_s = $signed({1'b0, cfg.view_w});
   assign vh_s = $signed({1'b0, cfg.view_h});

   always_comb begin
      mx6_in = (behind5_ff || nx5_ff <= 0) ? PIX_ZERO : PIX_CALC;
      my6_in = (behind5_ff || ny5_ff <= 0) ? PIX_ZERO : PIX_CALC;
      // Quotient too wide for the divider: saturate (covers a zero denominator).
      mx7_in = mx6_ff;
      my7_in = my6_ff;
      if (mx6_ff == PIX_CALC && nx6_ff >= NW'({denx6_ff, {QW{1'b0}}})) begin
         mx7_in = PIX_MAX;
      end
      if (my6_ff == PIX_CALC && ny6_ff >= NW'({deny6_ff, {QW{1'b0}}})) begin
         my7_in = PIX_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         behind4_ff <= depth <= DOT_W'(DEPTH_LIMIT);
         fx_ff      <= NUM_W'(cam_x) * NUM_W'(fl_s);
         dx_ff      <= NUM_W'(depth) * NUM_W'(vw_s);
         fy_ff      <= NUM_W'(cam_y) * NUM_W'(fl_s);
         dy_ff      <= NUM_W'(depth) * NUM_W'(vh_s);
      end
      if (en[1]) begin
         behind5_ff <= behind4_ff;
         nx5_ff     <= fx_ff + dx_ff;
         ny5_ff     <= dy_ff - fy_ff;
         denx5_ff   <= dx_ff[DEN_W-1:0];
         deny5_ff   <= dy_ff[DEN_W-1:0];
      end
      if (en[2]) begin
         behind6_ff <= behind5_ff;
         mx6_ff     <= mx6_in;
         my6_ff     <= my6_in;
         nx6_ff     <= NW'(nx5_ff[NUM_W-2:0]) * NW'(HALF_X);
         ny6_ff     <= NW'(ny5_ff[NUM_W-2:0]) * NW'(HALF_Y);
         denx6_ff   <= denx5_ff;
         deny6_ff   <= deny5_ff;
      end
      if (en[3]) begin
         behind7_ff <= behind6_ff;
         mx7_ff     <= mx7_in;
         my7_ff     <= my7_in;
         nx7_ff     <= nx6_ff;
         ny7_ff     <= ny6_ff;
         denx7_ff   <= denx6_ff;
         deny7_ff   <= deny6_ff;
      end
   end

   assign num_x  = nx7_ff;
   assign num_y  = ny7_ff;
   assign den_x  = denx7_ff;
   assign den_y  = deny7_ff;
   assign mode_x = mx7_ff;
   assign mode_y = my7_ff;
   assign behind = behind7_ff;

endmodule

// ===== rtl/core/ppp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Depends on ppp_pkg.
module ppp_div #(
   parameter int QW = 10,
   parameter int NW = ppp_pkg::NUM_W - 1 + QW
) (
   input  logic                        clock,
   input  logic [QW-1:0]               en,
   input  logic [NW-1:0]               num,
   input  logic [ppp_pkg::DEN_W-1:0]   den,
   input  ppp_pkg::pix_mode_type       mode_i,
   output logic [QW-1:0]               quot,
   output ppp_pkg::pix_mode_type       mode_o
);
   import ppp_pkg::*;

   logic [NW-1:0]    rem_ff  [QW];
   logic [QW-1:0]    q_ff    [QW];
   logic [DEN_W-1:0] den_ff  [QW];
   pix_mode_type     mode_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int B = QW - 1 - s;
      logic [NW-1:0]    rem_prev;
      logic [QW-1:0]    q_prev;
      logic [DEN_W-1:0] den_prev;
      pix_mode_type     mode_prev;
      logic [NW-1:0]    trial;
      logic             fits;

      if (s == 0) begin : g_first
         assign rem_prev  = num;
         assign q_prev    = '0;
         assign den_prev  = den;
         assign mode_prev = mode_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign q_prev    = q_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign mode_prev = mode_ff[s-1];
      end

      assign trial = NW'(den_prev) << B;
      assign fits  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= fits ? rem_prev - trial : rem_prev;
            q_ff[s]    <= fits ? (q_prev | (QW'(1) << B)) : q_prev;
            den_ff[s]  <= den_prev;
            mode_ff[s] <= mode_prev;
         end
      end
   end

   assign quot   = q_ff[QW-1];
   assign mode_o = mode_ff[QW-1];

endmodule

// ===== rtl/core/perspective_point_projector_core.sv =====
// Top level of the perspective point projector: config registers, stage valid chain,
// output stage. Depends on ppp_pkg, ppp_xform, ppp_persp and ppp_div.
//
//   channel  dir  payload
//   req_*    in   tdata[47:0] = point_x, point_y, point_z (signed Q8.8)
//   rsp_*    out  tdata[23:0] = pixel_x, pixel_y, 4 zero bits; tuser = behind_camera
//   csr_*    in   csr_we, csr_addr (register index), csr_wdata[47:0]
//
// Points pass the transform, perspective setup, one-bit-per-stage divider and output stages;
// one point enters per cycle unless a stalled rsp side holds the pipeline.
// Every stage keeps a valid bit and moves when it is empty or its successor moves,
// so a stalled rsp side fills bubbles before req_tready drops.
// Reset is synchronous: it clears all valid bits and loads the default camera.
module perspective_point_projector_core #(
   parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [3*ppp_pkg::LANE_W-1:0]      req_tdata,   // point_x, point_y, point_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // pixel_x, pixel_y, zero pad
   output logic                              rsp_tuser,   // behind_camera
   input  logic                              csr_we,
   input  logic [ppp_pkg::ADDR_W-1:0]        csr_addr,
   input  logic [ppp_pkg::REG_W-1:0]         csr_wdata
);
   import ppp_pkg::*;

   localparam int MAXDIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int QW     = $clog2(MAXDIM);
   localparam int NW     = NUM_W - 1 + QW;
   localparam int NS     = 8 + QW;

   // Configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_ORIGIN:      cfg_in.origin = csr_wdata;
            REG_BASIS_RIGHT: cfg_in.right  = csr_wdata;
            REG_BASIS_UP:    cfg_in.up     = csr_wdata;
            REG_BASIS_BACK:  cfg_in.back   = csr_wdata;
            REG_FOCAL:       cfg_in.focal  = csr_wdata[SIZE_W-1:0];
            REG_VIEW_W:      cfg_in.view_w = csr_wdata[SIZE_W-1:0];
            REG_VIEW_H:      cfg_in.view_h = csr_wdata[SIZE_W-1:0];
            default:         cfg_in = cfg_ff;   // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.right  <= REG_W'(48'h0000_0000_4000);
         cfg_ff.up     <= REG_W'(48'h0000_4000_0000);
         cfg_ff.back   <= REG_W'(48'h4000_0000_0000);
         cfg_ff.focal  <= SIZE_W'(256);
         cfg_ff.view_w <= SIZE_W'(512);
         cfg_ff.view_h <= SIZE_W'(384);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage valid chain: a stage advances when empty or when the next one advances
   logic [NS:1] v_ff, v_in, adv;

   always_comb begin
      adv[NS] = !v_ff[NS] || rsp_tready;
      for (int k = NS - 1; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      for (int k = 1; k <= NS; k++) begin
         if (adv[k]) begin
            v_in[k] = (k == 1) ? req_tvalid : v_ff[(k == 1) ? 1 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = adv[1];

   // Datapath
   logic signed [DOT_W-1:0] cam_x, cam_y, depth;
   logic [NW-1:0]           num_x, num_y;
   logic [DEN_W-1:0]        den_x, den_y;
   pix_mode_type            mode_x, mode_y, dmode_x, dmode_y;
   logic                    behind;
   logic [QW-1:0]           quot_x, quot_y;

   ppp_xform u_xform (
      .clock   (clock),
      .en      (adv[3:1]),
      .cfg     (cfg_ff),
      .point_x (req_tdata[LANE_W-1:0]),
      .point_y (req_tdata[2*LANE_W-1:LANE_W]),
      .point_z (req_tdata[3*LANE_W-1:2*LANE_W]),
      .cam_x   (cam_x),
      .cam_y   (cam_y),
      .depth   (depth)
   );

   ppp_persp #(
      .QW     (QW),
      .HALF_X (SCREEN_WIDTH / 2),
      .HALF_Y (SCREEN_HEIGHT / 2),
      .NW     (NW)
   ) u_persp (
      .clock  (clock),
      .en     (adv[7:4]),
      .cfg    (cfg_ff),
      .cam_x  (cam_x),
      .cam_y  (cam_y),
      .depth  (depth),
      .num_x  (num_x),
      .num_y  (num_y),
      .den_x  (den_x),
      .den_y  (den_y),
      .mode_x (mode_x),
      .mode_y (mode_y),
      .behind (behind)
   );

   ppp_div #(.QW(QW), .NW(NW)) u_div_x (
      .clock  (clock),
      .en     (adv[7+QW:8]),
      .num    (num_x),
      .den    (den_x),
      .mode_i (mode_x),
      .quot   (quot_x),
      .mode_o (dmode_x)
   );

   ppp_div #(.QW(QW), .NW(NW)) u_div_y (
      .clock  (clock),
      .en     (adv[7+QW:8]),
      .num    (num_y),
      .den    (den_y),
      .mode_i (mode_y),
      .quot   (quot_y),
      .mode_o (dmode_y)
   );

   // Carry the behind flag alongside the divider stages
   logic behind_ff [QW];

   always_ff @(posedge clock) begin
      for (int s = 0; s < QW; s++) begin
         if (adv[8+s]) begin
            behind_ff[s] <= (s == 0) ? behind : behind_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   // Output stage: clamp the quotient, force trivial pixels
   logic [QW-1:0]    pix_x_in, pix_y_in;
   logic [PIX_W-1:0] pix_x_ff, pix_y_ff;
   logic             behind_out_ff;

   always_comb begin
      case (dmode_x)
         PIX_ZERO: pix_x_in = '0;
         PIX_MAX:  pix_x_in = QW'(SCREEN_WIDTH - 1);
         default:  pix_x_in = (quot_x > QW'(SCREEN_WIDTH - 1)) ? QW'(SCREEN_WIDTH - 1) : quot_x;
      endcase
      case (dmode_y)
         PIX_ZERO: pix_y_in = '0;
         PIX_MAX:  pix_y_in = QW'(SCREEN_HEIGHT - 1);
         default:  pix_y_in = (quot_y > QW'(SCREEN_HEIGHT - 1)) ? QW'(SCREEN_HEIGHT - 1) : quot_y;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[NS]) begin
         pix_x_ff      <= PIX_W'(pix_x_in);
         pix_y_ff      <= PIX_W'(pix_y_in);
         behind_out_ff <= behind_ff[QW-1];
      end
   end

   assign rsp_tvalid = v_ff[NS];
   assign rsp_tdata  = {4'b0000, pix_y_ff, pix_x_ff};
   assign rsp_tuser  = behind_out_ff;

   // Assertions
   a_behind_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("behind-camera beat carries a nonzero pixel");

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !v_ff[NS] |-> req_tready)
      else $error("input stalled while the output stage is empty");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (SCREEN_WIDTH > 1024) || (rsp_tdata[9:0] < SCREEN_WIDTH))
      else $error("pixel column beyond screen width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (SCREEN_HEIGHT > 1024) || (rsp_tdata[19:10] < SCREEN_HEIGHT))
      else $error("pixel row beyond screen height");

endmodule
